// ----- hdl/sbda_pkg.sv -----
// Shared constants and sizing helpers for the signed binary to decimal ASCII converter.
package sbda_pkg;

	localparam int VALUE_BITS_DEF = 32;

	// input bits handled by one double-dabble stage
	localparam int STAGE_BITS = 8;

	localparam logic [5:0] ASCII_ZERO  = 6'd48;
	localparam logic [5:0] ASCII_NINE  = 6'd57;
	localparam logic [5:0] ASCII_MINUS = 6'd45;

	// decimal digits needed for any value below 2^bits (1233/4096 ~ log10(2))
	function automatic int digits_for(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

	// number of double-dabble stages for a given magnitude width
	function automatic int stages_for(input int bits);
		return (bits + STAGE_BITS - 1) / STAGE_BITS;
	endfunction

endpackage

// ----- hdl/signed_binary_to_decimal_ascii_top.sv -----
// The first character follows the magnitude, double-dabble and emitter registers.
// Throughput: one character per cycle while m_tready is high; a value has 1 to 11
// characters at 32 bits, as the emitter sends the sign and each digit as its own beat.
// The magnitude stage and the double-dabble stages take a new value every cycle while
// the emitter keeps draining; any stall freezes the whole pipeline.
// Reset (arst_n low, asynchronous) clears all valid bits and the emitter; nothing else.
module signed_binary_to_decimal_ascii_top #(
	parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,   // [VALUE_BITS-1:0] value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,   // [5:0] character, [7:6] zero
	output logic                               m_tlast
);
	import sbda_pkg::*;

	localparam int DIGITS     = digits_for(VALUE_BITS);
	localparam int NUM_STAGES = stages_for(VALUE_BITS);
	localparam int MAG_W      = NUM_STAGES * STAGE_BITS;
	localparam int BCD_W      = DIGITS * 4;

	logic                  adv;
	logic                  emit_ready;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  vld_s1;
	logic                  neg_s1;
	logic [MAG_W-1:0]      mag_s1;
	logic                  vld_p [NUM_STAGES+1];
	logic                  neg_p [NUM_STAGES+1];
	logic [MAG_W-1:0]      mag_p [NUM_STAGES+1];
	logic [BCD_W-1:0]      bcd_p [NUM_STAGES+1];
	logic [5:0]            character;

	// whole pipeline moves unless the last stage holds a value the emitter cannot take
	assign adv      = !vld_p[NUM_STAGES] || emit_ready;
	assign s_tready = adv;

	// magnitude, read as unsigned so the most negative value stays exact
	assign raw    = s_tdata[VALUE_BITS-1:0];
	assign mag_in = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			neg_s1 <= raw[VALUE_BITS-1];
			mag_s1 <= MAG_W'(mag_in);
		end
	end

	assign vld_p[0] = vld_s1;
	assign neg_p[0] = neg_s1;
	assign mag_p[0] = mag_s1;
	assign bcd_p[0] = '0;

	// double-dabble stages
	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
		sbda_dabble #(
			.MAG_W  (MAG_W),
			.DIGITS (DIGITS)
		) u_dabble (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (vld_p[g]),
			.in_neg    (neg_p[g]),
			.in_mag    (mag_p[g]),
			.in_bcd    (bcd_p[g]),
			.out_valid (vld_p[g+1]),
			.out_neg   (neg_p[g+1]),
			.out_mag   (mag_p[g+1]),
			.out_bcd   (bcd_p[g+1])
		);
	end

	sbda_emit #(
		.DIGITS (DIGITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_p[NUM_STAGES]),
		.in_neg    (neg_p[NUM_STAGES]),
		.in_bcd    (bcd_p[NUM_STAGES]),
		.in_ready  (emit_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (character),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, character};

	// every beat is a minus sign or a digit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (character == ASCII_MINUS ||
			(character >= ASCII_ZERO && character <= ASCII_NINE)))
		else $error("emitted character out of range");

	// a minus sign is never the final beat of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && character == ASCII_MINUS) |-> !m_tlast)
		else $error("run ends on a minus sign");

	// the pipeline only stalls while the emitter holds a value
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("pipeline stalled with idle emitter");

endmodule

// ----- hdl/sbda_dabble.sv -----
// One double-dabble pipeline stage: shifts STAGE_BITS magnitude bits into the BCD digits.
module sbda_dabble #(
	parameter int MAG_W  = 32,
	parameter int DIGITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic                in_neg,
	input  logic [MAG_W-1:0]    in_mag,
	input  logic [DIGITS*4-1:0] in_bcd,
	output logic                out_valid,
	output logic                out_neg,
	output logic [MAG_W-1:0]    out_mag,
	output logic [DIGITS*4-1:0] out_bcd
);
	import sbda_pkg::*;

	localparam int BCD_W = DIGITS * 4;

	logic             vld_s1;
	logic             neg_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [BCD_W-1:0] bcd_s1;
	logic [BCD_W-1:0] bcd_nx;

	// add-3 correction then shift in one magnitude bit, MSB first, for each of STAGE_BITS bits
	always_comb begin
		bcd_nx = in_bcd;
		for (int i = 0; i < STAGE_BITS; i++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_nx[d*4 +: 4] >= 4'd5)
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], in_mag[MAG_W-1-i]};
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			neg_s1 <= in_neg;
			mag_s1 <= in_mag << STAGE_BITS;
			bcd_s1 <= bcd_nx;
		end
	end

	assign out_valid = vld_s1;
	assign out_neg   = neg_s1;
	assign out_mag   = mag_s1;
	assign out_bcd   = bcd_s1;

endmodule

// ----- hdl/sbda_emit.sv -----
// Character emitter: holds one converted value and sends its text one beat per character.
module sbda_emit #(
	parameter int DIGITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_neg,
	input  logic [DIGITS*4-1:0] in_bcd,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [5:0]          out_char,
	output logic                out_last
);
	import sbda_pkg::*;

	localparam int BCD_W = DIGITS * 4;
	localparam int IDX_W = $clog2(DIGITS);

	logic             busy_q;
	logic             sign_q;
	logic [IDX_W-1:0] pos_q;
	logic [BCD_W-1:0] bcd_q;
	logic [IDX_W-1:0] lead;
	logic [3:0]       digit;
	logic             last_beat;
	logic             done;
	logic             load;

	// highest nonzero digit, zero gives the units digit
	always_comb begin
		lead = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (in_bcd[d*4 +: 4] != 4'd0)
				lead = IDX_W'(d);
		end
	end

	assign last_beat = !sign_q && (pos_q == '0);
	assign done      = busy_q && out_ready && last_beat;
	assign in_ready  = !busy_q || done;
	assign load      = in_valid && in_ready;

	// walk: sign first, then digits from the leading one down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			sign_q <= in_neg;
			pos_q  <= lead;
		end else if (busy_q && out_ready) begin
			if (last_beat)
				busy_q <= 1'b0;
			else if (sign_q)
				sign_q <= 1'b0;
			else
				pos_q <= pos_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			bcd_q <= in_bcd;
	end

	assign digit     = bcd_q[pos_q*4 +: 4];
	assign out_valid = busy_q;
	assign out_char  = sign_q ? ASCII_MINUS : (ASCII_ZERO + {2'b00, digit});
	assign out_last  = last_beat;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for the signed binary to decimal ASCII converter, checking every character beat.
module testbench;
	import sbda_pkg::*;

	localparam int VALUE_BITS   = 32;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 16;

	// one predicted character of the decimal text
	typedef struct packed {
		logic [5:0] character;
		logic       last;
	} text_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [31:0] value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [5:0] character, [7:6] zero
	logic        m_tlast;

	text_beat_t  expected_text[$];
	text_beat_t  want_beat;
	int          error_count   = 0;
	int          cycle_count   = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_active   = 1'b0;
	event        hold_trigger;

	signed_binary_to_decimal_ascii_top #(.VALUE_BITS(VALUE_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// decimal text of a 32-bit two's-complement value, sign first, then digits MSD first
	function automatic void queue_decimal_text(input logic [31:0] value);
		logic       negative;
		logic [31:0] magnitude;
		logic [3:0] digit_q[$];
		text_beat_t beat;
		negative  = value[31];
		// 32-bit negate gives 2^31 for the most negative value, read as unsigned
		magnitude = negative ? (~value + 32'd1) : value;
		do begin
			digit_q.push_front(4'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (negative) begin
			beat.character = ASCII_MINUS;
			beat.last      = 1'b0;
			expected_text.push_back(beat);
		end
		while (digit_q.size() > 0) begin
			beat.character = ASCII_ZERO + 6'(digit_q.pop_front());
			beat.last      = (digit_q.size() == 0);
			expected_text.push_back(beat);
		end
	endfunction

	// receiver: random stalls, or a long hold-off when triggered
	always @(posedge clk) begin
		if (hold_active)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always begin
		@(hold_trigger);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	// output checker: compare each beat with the oldest predicted character
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected beat tdata=%02h last=%0b",
					m_tdata, m_tlast));
			end else begin
				want_beat = expected_text.pop_front();
				if (m_tdata !== {2'b00, want_beat.character})
					report_mismatch($sformatf("character %02h, want %02h",
						m_tdata, {2'b00, want_beat.character}));
				if (m_tlast !== want_beat.last)
					report_mismatch($sformatf("last %0b, want %0b",
						m_tlast, want_beat.last));
			end
		end
	end

	// send one value; s_tready is sampled at the falling edge, inputs only move at rising edges
	task automatic send_value(input logic [31:0] value);
		logic ready_seen;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end while (!ready_seen);
		queue_decimal_text(value);
	endtask

	// wait for all predicted text, then let the pipeline settle
	task automatic wait_for_text();
		s_tvalid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// spread over all digit counts, both signs, plus fully random words
	function automatic logic [31:0] random_value();
		logic [31:0] v;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		v = $urandom >> $urandom_range(0, 31);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic test_edge_values();
		logic [31:0] edge_list[$];
		edge_list = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
			32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
			32'd123456789, -32'sd123456789, 32'd7, -32'sd5};
		foreach (edge_list[i])
			send_value(edge_list[i]);
	endtask

	task automatic test_random_values(input int count);
		repeat (count)
			send_value(random_value());
	endtask

	// long output hold-off while input keeps coming: the pipeline must fill and stall
	task automatic test_output_stall(input int count);
		s_tvalid <= 1'b0;
		@(posedge clk);
		-> hold_trigger;
		repeat (count)
			send_value(random_value());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 12;
		recv_stall_pct = 51;
		test_edge_values();
		test_random_values(80);
		wait_for_text();

		send_idle_pct  = 51;
		recv_stall_pct = 12;
		test_random_values(80);
		wait_for_text();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_values(60);
		test_output_stall(30);
		wait_for_text();

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
